// ===== src/cqrb_pkg.sv =====
// Package for the circular queue ring buffer.
// Holds field widths, request and status codes, and controller/datapath types.
// No dependencies.
`default_nettype none

package cqrb_pkg;

    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 5;
    localparam int MAX_OUT   = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_DELETE   = 2'd1,
        REQ_TRAVERSE = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_FULL,
        OP_EMPTY,
        OP_DELETE,
        OP_TRAV_FIRST,
        OP_TRAV_NEXT
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/cqrb_ctrl.sv =====
// Controller state machine for the circular queue ring buffer.
// Decodes requests into datapath operations and runs the handshakes.
// Depends on cqrb_pkg.
`default_nettype none

module cqrb_ctrl
    import cqrb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [REQ_W-1:0]   s_tuser,
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire dp_stat_t           stat,
    output      op_t                op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (req_t'(s_tuser))
                        REQ_INSERT: begin
                            op         = (stat.empty || !stat.full) ? OP_INSERT : OP_FULL;
                            state_next = ST_SEND;
                        end
                        REQ_DELETE: begin
                            op         = stat.empty ? OP_EMPTY : OP_DELETE;
                            state_next = ST_SEND;
                        end
                        REQ_TRAVERSE: begin
                            op         = stat.empty ? OP_EMPTY : OP_TRAV_FIRST;
                            state_next = ST_SEND;
                        end
                        default: begin
                            op = OP_NONE;
                        end
                    endcase
                end
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        op = OP_TRAV_NEXT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cqrb_dp.sv =====
// Datapath for the circular queue ring buffer.
// Slot memory, head/tail/traverse pointers, capacity register and result registers.
// Depends on cqrb_pkg.
`default_nettype none

module cqrb_dp
    import cqrb_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire op_t                 op,
    input  wire logic [DATA_W-1:0]   s_tdata,
    input  wire logic                cfg_wen,
    input  wire logic [CAP_W-1:0]    cfg_wdata,
    output      dp_stat_t            stat,
    output      logic [STAT_W-1:0]   m_tuser,
    output      logic [DATA_W-1:0]   m_tdata,
    output      logic                m_tlast
);

    localparam int SLOTS = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CAP_W-1:0] SLOTS_CAP = CAP_W'(SLOTS);

    logic [DATA_W-1:0] mem [SLOTS];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              empty_reg, empty_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              last_reg, last_next;
    logic              zero_reg, zero_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic [CAP_W-1:0]  cap_eff;
    logic [IDX_W-1:0]  tail_wrap;
    logic [IDX_W-1:0]  head_wrap;
    logic [IDX_W-1:0]  ptr_wrap;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W:0] nxt;
        nxt = (CAP_W+1)'(i) + 1'b1;
        if (nxt >= (CAP_W+1)'(cap)) begin
            wrap_next = '0;
        end else begin
            wrap_next = nxt[IDX_W-1:0];
        end
    endfunction

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (cap_reg > SLOTS_CAP) begin
            cap_eff = SLOTS_CAP;
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign tail_wrap = wrap_next(tail_reg, cap_eff);
    assign head_wrap = wrap_next(head_reg, cap_eff);
    assign ptr_wrap  = wrap_next(ptr_reg, cap_eff);

    assign stat.empty = empty_reg;
    assign stat.full  = (tail_wrap == head_reg);
    assign stat.last  = last_reg;

    assign m_tuser = status_reg;
    assign m_tdata = zero_reg ? '0 : rd_data_reg;
    assign m_tlast = last_reg;

    assign rd_addr = (op == OP_TRAV_NEXT) ? ptr_reg : head_reg;
    assign rd_en   = (op == OP_DELETE) || (op == OP_TRAV_FIRST) || (op == OP_TRAV_NEXT);
    assign wr_en   = (op == OP_INSERT);
    assign wr_addr = empty_reg ? '0 : tail_wrap;

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        ptr_next    = ptr_reg;
        empty_next  = empty_reg;
        cap_next    = cap_reg;
        status_next = status_reg;
        last_next   = last_reg;
        zero_next   = zero_reg;
        case (op)
            OP_INSERT: begin
                if (empty_reg) begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                end else begin
                    tail_next = tail_wrap;
                end
                status_next = STAT_OK;
                last_next   = 1'b1;
                zero_next   = 1'b1;
            end
            OP_FULL: begin
                status_next = STAT_FULL;
                last_next   = 1'b1;
                zero_next   = 1'b1;
            end
            OP_EMPTY: begin
                status_next = STAT_EMPTY;
                last_next   = 1'b1;
                zero_next   = 1'b1;
            end
            OP_DELETE: begin
                if (head_reg == tail_reg) begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end else begin
                    head_next = head_wrap;
                end
                status_next = STAT_OK;
                last_next   = 1'b1;
                zero_next   = 1'b0;
            end
            OP_TRAV_FIRST: begin
                ptr_next    = head_wrap;
                status_next = STAT_OK;
                last_next   = (head_reg == tail_reg);
                zero_next   = 1'b0;
            end
            OP_TRAV_NEXT: begin
                ptr_next    = ptr_wrap;
                status_next = STAT_OK;
                last_next   = (ptr_reg == tail_reg);
                zero_next   = 1'b0;
            end
            default: begin
                if (cfg_wen && empty_reg) begin
                    cap_next  = cfg_wdata;
                    head_next = '0;
                    tail_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            ptr_reg    <= '0;
            empty_reg  <= 1'b1;
            cap_reg    <= CAP_RESET;
            status_reg <= STAT_OK;
            last_reg   <= 1'b1;
            zero_reg   <= 1'b1;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            ptr_reg    <= ptr_next;
            empty_reg  <= empty_next;
            cap_reg    <= cap_next;
            status_reg <= status_next;
            last_reg   <= last_next;
            zero_reg   <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/circular_queue_ring_buffer.sv =====
// Circular queue ring buffer of signed 32-bit words, top level.
// Ties the controller (cqrb_ctrl) to the datapath (cqrb_dp); uses cqrb_pkg.
//
// Requests arrive on s_tuser (0 insert, 1 delete, 2 traverse, 3 ignored) with
// the insert word on s_tdata. Every request except an ignored one returns one
// beat, status on m_tuser (0 ok, 1 full, 2 empty), data on m_tdata and m_tlast
// high; a traverse of a nonempty queue returns one beat per stored word, oldest
// first, with m_tlast on the newest. The controller takes a request, then holds
// input off while it sends the results, reading one slot per beat through the
// single read port of the slot memory. capacity (cfg_wdata, reset 5) sets the
// wrap modulus, clamped to 1..min(DEPTH, 16); a write while the queue holds
// words is dropped. Slot storage is min(DEPTH, 16) words.
`default_nettype none

module circular_queue_ring_buffer
    import cqrb_pkg::*;
#(
    parameter int DEPTH = 16
)(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [DATA_W-1:0]   s_tdata,   // [31:0] data_in
    input  wire logic [REQ_W-1:0]    s_tuser,   // [1:0] req_type
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [DATA_W-1:0]   m_tdata,   // [31:0] data_out
    output      logic [STAT_W-1:0]   m_tuser,   // [1:0] status
    output      logic                m_tlast,
    input  wire logic                cfg_wen,
    input  wire logic [CAP_W-1:0]    cfg_wdata
);

    op_t      op;
    dp_stat_t stat;

    cqrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .op       (op)
    );

    cqrb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
